/* rtl/hilbert_curve_encoder_2d_unit_macros.svh */
// Assertion macros used by the encoder top level.
`ifndef HILBERT_CURVE_ENCODER_2D_UNIT_MACROS_SVH
`define HILBERT_CURVE_ENCODER_2D_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Condition must hold at every clock edge out of reset.
`define HC_ASSERT(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// When ante holds, cons must hold in the next cycle.
`define HC_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define HC_ASSERT(name, cond, msg)
`define HC_ASSERT_NEXT(name, ante, cons, msg)

`endif

`endif

/* rtl/hcenc_pkg.sv */
`default_nettype none

package hcenc_pkg;

  localparam int AxisBits = 16;
  localparam int IndexBits = 2 * AxisBits;
  localparam logic [AxisBits-1:0] AxisMask = 16'hFFFF;

  // Orientation words carried between scan cells
  typedef struct packed {
    logic [AxisBits-1:0] p;
    logic [AxisBits-1:0] q;
    logic [AxisBits-1:0] r;
    logic [AxisBits-1:0] s;
    logic [AxisBits-1:0] lo;     // x ^ y after alignment
    logic [4:0]          order;  // effective order, 1..16
  } stage_t;

  // Clamp the register value into 1..max_order
  function automatic logic [4:0] eff_order(logic [4:0] ord, logic [4:0] max_order);
    logic [4:0] n;
    n = ord;
    if (n == 5'd0) begin
      n = 5'd1;
    end
    if (n > max_order) begin
      n = max_order;
    end
    if (n > 5'(AxisBits)) begin
      n = 5'(AxisBits);
    end
    return n;
  endfunction

endpackage

`default_nettype wire

/* rtl/hilbert_curve_encoder_2d_unit.sv */
// Channel   | Direction | Handshake           | Payload
// ----------+-----------+---------------------+----------------------------
// cfg       | in        | psel/penable/pready | paddr, pwdata, prdata
// in        | in        | in_valid/in_ready   | x_coord, y_coord
// out       | out       | out_valid/out_ready | curve_index
//
// One coordinate pair per cycle while the output is not stalled by out_ready.
// The depth is the seed round, three scan cells (distance 2, 4, 8) and the output register.
// Every stage holds its beat only while the next one is stalled, so bubbles collapse.
// Reset (rst, synchronous) empties the chain and sets curve_order to 16.
`default_nettype none
`include "hilbert_curve_encoder_2d_unit_macros.svh"

module hilbert_curve_encoder_2d_unit import hcenc_pkg::*; #(
  parameter int MAX_ORDER = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [15:0] x_coord,
  input  wire logic [15:0] y_coord,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      curve_index
);

  localparam int NumCells = 3;
  localparam logic RegOrder = 1'b0;

  logic [4:0] curve_order;
  logic       reg_sel;

  stage_t link_data  [NumCells+1];
  logic   link_valid [NumCells+1];
  logic   link_ready [NumCells+1];

  // Configuration register
  assign pready  = 1'b1;
  assign reg_sel = paddr[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      curve_order <= 5'd16;
    end else if (psel && penable && pwrite && reg_sel == RegOrder) begin
      curve_order <= pwdata[4:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_sel == RegOrder) begin
      prdata = {27'd0, curve_order};
    end
  end

  // Seed round
  hcenc_seed #(
    .MAX_ORDER (MAX_ORDER)
  ) u_seed (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .x_coord     (x_coord),
    .y_coord     (y_coord),
    .curve_order (curve_order),
    .out_valid   (link_valid[0]),
    .out_ready   (link_ready[0]),
    .out_data    (link_data[0])
  );

  // Scan cells at doubling distance
  for (genvar k = 0; k < NumCells; k++) begin : g_cell
    hcenc_cell #(
      .DIST (2 << k)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (link_valid[k]),
      .in_ready  (link_ready[k]),
      .in_data   (link_data[k]),
      .out_valid (link_valid[k+1]),
      .out_ready (link_ready[k+1]),
      .out_data  (link_data[k+1])
    );
  end

  // Plane recovery and interleave
  hcenc_out u_out (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (link_valid[NumCells]),
    .in_ready    (link_ready[NumCells]),
    .in_data     (link_data[NumCells]),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .curve_index (curve_index)
  );

  // Input only backs up when the whole chain is full behind a stalled output
  `HC_ASSERT(a_stall_from_out, in_ready || (out_valid && !out_ready), "input stalled without output stall")
  // An empty output stage lets everything flow
  `HC_ASSERT(a_empty_out_ready, out_valid || in_ready, "input stalled with empty output")
  // A new result only appears if the last cell held a beat
  `HC_ASSERT_NEXT(a_out_from_chain, !out_valid && !link_valid[NumCells], !out_valid, "result without source beat")

endmodule

`default_nettype wire

/* rtl/hcenc_seed.sv */
`default_nettype none

module hcenc_seed import hcenc_pkg::*; #(
  parameter int MAX_ORDER = 16
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [15:0]   x_coord,
  input  wire logic [15:0]   y_coord,
  input  wire logic [4:0]    curve_order,
  output logic               out_valid,
  input  wire logic          out_ready,
  output stage_t             out_data
);

  localparam logic [4:0] MaxOrd = 5'(MAX_ORDER);

  logic            valid;
  stage_t          data;
  stage_t          data_next;
  logic [4:0]      n;
  logic [16:0]     keep_w;
  logic [15:0]     keep;
  logic [4:0]      sh;
  logic [15:0]     x;
  logic [15:0]     y;
  logic [15:0]     p;
  logic [15:0]     q;
  logic [15:0]     r;
  logic [15:0]     s;

  // Mask to the order and left-align to the full axis width
  always_comb begin
    n      = eff_order(curve_order, MaxOrd);
    keep_w = (17'd1 << n) - 17'd1;
    keep   = keep_w[15:0];
    sh     = 5'(AxisBits) - n;
    x      = (x_coord & keep) << sh;
    y      = (y_coord & keep) << sh;
  end

  // First scan round, seeded from the coordinates
  always_comb begin
    p = x ^ y;
    q = AxisMask ^ p;
    r = AxisMask ^ (x | y);
    s = x & (y ^ AxisMask);
    data_next.p     = p | (q >> 1);
    data_next.q     = (p >> 1) ^ p;
    data_next.r     = ((r >> 1) ^ (q & (s >> 1))) ^ r;
    data_next.s     = ((p & (r >> 1)) ^ (s >> 1)) ^ s;
    data_next.lo    = x ^ y;
    data_next.order = n;
  end

  assign in_ready = !valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      data <= data_next;
    end
  end

  assign out_valid = valid;
  assign out_data  = data;

endmodule

`default_nettype wire

/* rtl/hcenc_cell.sv */
`default_nettype none

module hcenc_cell import hcenc_pkg::*; #(
  parameter int DIST = 2
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire stage_t in_data,
  output logic       out_valid,
  input  wire logic  out_ready,
  output stage_t     out_data
);

  logic   valid;
  stage_t data;
  stage_t data_next;

  // One prefix-scan round at the given distance
  always_comb begin
    data_next.p = (in_data.p & (in_data.p >> DIST)) ^ (in_data.q & (in_data.q >> DIST));
    data_next.q = (in_data.p & (in_data.q >> DIST))
                ^ (in_data.q & ((in_data.p ^ in_data.q) >> DIST));
    data_next.r = in_data.r ^ ((in_data.p & (in_data.r >> DIST))
                ^ (in_data.q & (in_data.s >> DIST)));
    data_next.s = in_data.s ^ ((in_data.q & (in_data.r >> DIST))
                ^ ((in_data.p ^ in_data.q) & (in_data.s >> DIST)));
    data_next.lo    = in_data.lo;
    data_next.order = in_data.order;
  end

  assign in_ready = !valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      data <= data_next;
    end
  end

  assign out_valid = valid;
  assign out_data  = data;

endmodule

`default_nettype wire

/* rtl/hcenc_out.sv */
`default_nettype none

module hcenc_out import hcenc_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire stage_t       in_data,
  output logic              out_valid,
  input  wire logic         out_ready,
  output logic [31:0]       curve_index
);

  logic        valid;
  logic [31:0] index;
  logic [31:0] index_next;
  logic [15:0] pl;
  logic [15:0] ql;
  logic [15:0] hi;
  logic [31:0] woven;
  logic [5:0]  sh;

  // Undo the scan and recover the two index planes
  always_comb begin
    pl = in_data.r ^ (in_data.r >> 1);
    ql = in_data.s ^ (in_data.s >> 1);
    hi = ql | (AxisMask ^ (in_data.lo | pl));
  end

  // Interleave planes, then drop the unused low bits
  always_comb begin
    for (int i = 0; i < AxisBits; i++) begin
      woven[2*i]   = in_data.lo[i];
      woven[2*i+1] = hi[i];
    end
    sh         = 6'(IndexBits) - {in_data.order, 1'b0};
    index_next = woven >> sh;
  end

  assign in_ready = !valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      index <= index_next;
    end
  end

  assign out_valid   = valid;
  assign curve_index = index;

endmodule

`default_nettype wire

/* dv/hilbert_curve_encoder_2d_unit_test.sv */
`default_nettype none

module hilbert_curve_encoder_2d_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import hcenc_pkg::*;

  // Register map: index 0 is the order, index 1 has no register behind it
  localparam logic [2:0] AddrCurveOrder = 3'd0;
  localparam logic [2:0] AddrSpare      = 3'd4;
  localparam logic [4:0] OrderAtReset   = 5'd16;
  localparam int         SegItems       = 60;
  localparam int         SettleCycles   = 10;

  // Directed stimulus row; idx is used only when known is set
  typedef struct packed {
    logic [4:0]          order;
    logic                spare_write;
    logic [AxisBits-1:0] x;
    logic [AxisBits-1:0] y;
    logic                known;
    logic [IndexBits-1:0] idx;
  } pair_row_t;

  localparam int NumRows = 23;
  localparam pair_row_t DirRows [NumRows] = '{
    // reset order, corners and mixed bits
    '{5'd16, 1'b0, 16'h0000, 16'h0000, 1'b1, 32'd0},
    '{5'd16, 1'b0, 16'hFFFF, 16'hFFFF, 1'b0, 32'd0},
    '{5'd16, 1'b0, 16'hFFFF, 16'h0000, 1'b0, 32'd0},
    '{5'd16, 1'b0, 16'h0000, 16'hFFFF, 1'b0, 32'd0},
    '{5'd16, 1'b0, 16'h8000, 16'h0000, 1'b0, 32'd0},
    '{5'd16, 1'b0, 16'h1234, 16'hABCD, 1'b0, 32'd0},
    // write to an unmapped index must leave the order alone
    '{5'd16, 1'b1, 16'h0001, 16'h0000, 1'b0, 32'd0},
    // order 1 walks the four cells of the base pattern
    '{5'd1,  1'b0, 16'h0000, 16'h0000, 1'b1, 32'd0},
    '{5'd1,  1'b0, 16'h0000, 16'h0001, 1'b1, 32'd1},
    '{5'd1,  1'b0, 16'h0001, 16'h0001, 1'b1, 32'd2},
    '{5'd1,  1'b0, 16'h0001, 16'h0000, 1'b1, 32'd3},
    // bits above the order are dropped
    '{5'd1,  1'b0, 16'hFFFF, 16'hFFFE, 1'b1, 32'd3},
    // order zero behaves as order 1
    '{5'd0,  1'b0, 16'h0001, 16'h0001, 1'b1, 32'd2},
    '{5'd0,  1'b0, 16'h0000, 16'h0001, 1'b1, 32'd1},
    // orders above the maximum clamp to 16
    '{5'd31, 1'b0, 16'h0000, 16'h0000, 1'b1, 32'd0},
    '{5'd31, 1'b0, 16'hFFFF, 16'hFFFF, 1'b0, 32'd0},
    '{5'd31, 1'b0, 16'h5555, 16'hAAAA, 1'b0, 32'd0},
    '{5'd17, 1'b0, 16'hAAAA, 16'h5555, 1'b0, 32'd0},
    // mid orders
    '{5'd8,  1'b0, 16'h00FF, 16'h0000, 1'b0, 32'd0},
    '{5'd8,  1'b0, 16'hFF00, 16'h00FF, 1'b0, 32'd0},
    '{5'd15, 1'b0, 16'h7FFF, 16'h4000, 1'b0, 32'd0},
    '{5'd15, 1'b0, 16'hFFFF, 16'h8000, 1'b0, 32'd0},
    '{5'd2,  1'b0, 16'h0003, 16'h0002, 1'b0, 32'd0}
  };

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [2:0]           paddr = '0;
  logic [31:0]          pwdata = '0;
  logic [31:0]          prdata;
  logic                 pready;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [AxisBits-1:0]  x_coord = '0;
  logic [AxisBits-1:0]  y_coord = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [IndexBits-1:0] curve_index;

  logic [4:0]           order_q = OrderAtReset;
  logic [IndexBits-1:0] pending_index[$];
  int                   idle_pct = 0;
  int                   stall_pct = 0;
  int                   errors = 0;

  hilbert_curve_encoder_2d_unit i_dut (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .x_coord     (x_coord),
    .y_coord     (y_coord),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .curve_index (curve_index)
  );

  always #1 clk = ~clk;

  // Hilbert position of (xi, yi) for a raw order register value
  function automatic logic [IndexBits-1:0] hilbert_pos(logic [4:0] ord,
                                                       logic [AxisBits-1:0] xi,
                                                       logic [AxisBits-1:0] yi);
    logic [4:0]           n;
    logic [AxisBits-1:0]  keep, x, y, p, q, r, s, np, nq, nr, ns, lo, hi;
    logic [IndexBits-1:0] woven;
    int                   hop;
    n = (ord == 5'd0) ? 5'd1 : ord;
    if (n > 5'd16) begin
      n = 5'd16;
    end
    keep = (n == 5'd16) ? 16'hFFFF : ((16'd1 << n) - 16'd1);
    x = (xi & keep) << (16 - n);
    y = (yi & keep) << (16 - n);

    // seed round
    p = x ^ y;
    q = ~p;
    r = ~(x | y);
    s = x & ~y;
    np = p | (q >> 1);
    nq = (p >> 1) ^ p;
    nr = ((r >> 1) ^ (q & (s >> 1))) ^ r;
    ns = ((p & (r >> 1)) ^ (s >> 1)) ^ s;

    // scan rounds at distance 2 and 4
    for (hop = 2; hop <= 4; hop = hop * 2) begin
      p = np; q = nq; r = nr; s = ns;
      np = (p & (p >> hop)) ^ (q & (q >> hop));
      nq = (p & (q >> hop)) ^ (q & ((p ^ q) >> hop));
      nr = r ^ ((p & (r >> hop)) ^ (q & (s >> hop)));
      ns = s ^ ((q & (r >> hop)) ^ ((p ^ q) & (s >> hop)));
    end

    // distance 8 needs only r and s
    p = np; q = nq; r = nr; s = ns;
    nr = r ^ ((p & (r >> 8)) ^ (q & (s >> 8)));
    ns = s ^ ((q & (r >> 8)) ^ ((p ^ q) & (s >> 8)));

    // index planes, then interleave hi over lo
    p  = nr ^ (nr >> 1);
    q  = ns ^ (ns >> 1);
    lo = x ^ y;
    hi = q | ~(lo | p);
    for (int i = 0; i < AxisBits; i++) begin
      woven[2*i]   = lo[i];
      woven[2*i+1] = hi[i];
    end
    return woven >> (32 - 2 * n);
  endfunction

  // Random coordinate, biased toward the edges of the active grid
  function automatic logic [AxisBits-1:0] pick_coord(logic [4:0] ord);
    logic [AxisBits-1:0] span;
    span = (ord == 5'd0) ? 16'h0001 : (ord >= 5'd16) ? 16'hFFFF : ((16'd1 << ord) - 16'd1);
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2: return span;
      3: return AxisBits'($urandom()) & span;
      default: return AxisBits'($urandom());
    endcase
  endfunction

  // Receiver stall
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Output check against the oldest expected index
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_index.size() == 0) begin
        $error("curve_index: unexpected beat, got %h", curve_index);
        errors++;
      end else if (curve_index !== pending_index[0]) begin
        $error("curve_index mismatch: expected %h, got %h", pending_index[0], curve_index);
        errors++;
        void'(pending_index.pop_front());
      end else begin
        void'(pending_index.pop_front());
      end
    end
  end

  // Send one coordinate pair and record what it should produce
  task automatic send_pair(input logic [AxisBits-1:0] x, input logic [AxisBits-1:0] y,
                           input logic known, input logic [IndexBits-1:0] idx);
    logic [IndexBits-1:0] want;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    x_coord  <= x;
    y_coord  <= y;
    want = known ? idx : hilbert_pos(order_q, x, y);
    do @(posedge clk); while (!in_ready);
    pending_index.push_back(want);
  endtask

  // Stop sending and let the pipeline empty
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_index.size() != 0) begin
      @(posedge clk);
    end
    repeat (SettleCycles) @(posedge clk);
  endtask

  // APB write: setup then access
  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (addr == AddrCurveOrder) begin
      order_q = data[4:0];
    end
  endtask

  initial begin
    int send_idle [4];
    int recv_stall [4];
    logic [4:0] seg_order;
    send_idle  = '{0, 60, 0, 11};
    recv_stall = '{0, 0, 60, 11};

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed rows
    foreach (DirRows[i]) begin
      if (DirRows[i].spare_write) begin
        drain();
        write_reg(AddrSpare, {27'h0, DirRows[i].order} ^ 32'h1F);
      end else if (DirRows[i].order != order_q) begin
        drain();
        write_reg(AddrCurveOrder, {27'h0, DirRows[i].order});
      end
      send_pair(DirRows[i].x, DirRows[i].y, DirRows[i].known, DirRows[i].idx);
    end

    // random segments under each idling mix, several orders each
    for (int ph = 0; ph < 4; ph++) begin
      drain();
      idle_pct  = send_idle[ph];
      stall_pct = recv_stall[ph];
      for (int seg = 0; seg < 6; seg++) begin
        case (seg)
          0: seg_order = 5'd16;
          1: seg_order = 5'd1;
          2: seg_order = 5'd0;
          3: seg_order = 5'd31;
          default: seg_order = 5'($urandom_range(2, 15));
        endcase
        drain();
        write_reg(AddrCurveOrder, ($urandom() & ~32'h1F) | {27'h0, seg_order});
        if ($urandom_range(3) == 0) begin
          write_reg(AddrSpare, $urandom());
        end
        for (int k = 0; k < SegItems; k++) begin
          send_pair(pick_coord(order_q), pick_coord(order_q), 1'b0, '0);
        end
      end
    end

    drain();
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #1_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

`default_nettype wire
